// ===== src/pps_pkg.sv =====
// Shared types for the pulse period smoother: the request item, the result item and
// the records passed between its pipeline stages.
// Depends on nothing; every other file uses it.
`default_nettype none

package pps_pkg;

   localparam int unsigned WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type rise_a;
      word_type rise_b;
   } item_type;

   typedef struct packed {
      word_type pulse_period_out;
      word_type sync_offset_out;
   } result_type;

   // Input slot as seen by the smoothing core.
   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   // Result write into the output register.
   typedef struct packed {
      logic       load;
      result_type result;
   } load_type;

endpackage

`default_nettype wire

// ===== src/pps_if.sv =====
// Valid/ready channel interfaces for the pulse period smoother: request and response.
// Depends on pps_pkg for the field widths.
`default_nettype none

interface pps_req_if;
   logic              valid;
   logic              ready;
   pps_pkg::word_type rise_a;
   pps_pkg::word_type rise_b;

   modport source (output valid, output rise_a, output rise_b, input ready);
   modport sink   (input valid, input rise_a, input rise_b, output ready);
endinterface

interface pps_rsp_if;
   logic              valid;
   logic              ready;
   pps_pkg::word_type pulse_period_out;
   pps_pkg::word_type sync_offset_out;

   modport source (output valid, output pulse_period_out, output sync_offset_out,
                   input ready);
   modport sink   (input valid, input pulse_period_out, input sync_offset_out,
                   output ready);
endinterface

`default_nettype wire

// ===== src/pps_in_stage.sv =====
// Input register of the pulse period smoother: captures one request transfer.
// Depends on pps_pkg.
`default_nettype none

module pps_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pps_pkg::item_type req_item,
   input  wire logic              advance,
   output pps_pkg::slot_type      slot
);

   logic              valid_ff, valid_in;
   pps_pkg::item_type item_ff, item_in;
   logic              take;

   // Free the slot whenever its item moves on in the same cycle.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

`default_nettype wire

// ===== src/pps_core.sv =====
// Smoothing core: tracker state, repeat-stamp drop and the two 0.9/0.1 filter updates.
// Depends on pps_pkg.
`default_nettype none

module pps_core #(
   parameter logic [31:0] INIT_PERIOD = 32'd8333,
   parameter logic [31:0] INIT_OFFSET = 32'd400
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pps_pkg::slot_type slot,
   input  wire logic              out_busy,
   output logic                   advance,
   output pps_pkg::load_type      load
);

   // floor(n/10) = (n * ceil(2^35/10)) >> 35, exact for n below 2^34.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;
   // Bias that keeps the signed difference non-negative; a multiple of ten.
   localparam logic [33:0] DIFF_BIAS   = 34'd4294967300;
   localparam logic [31:0] BIAS_TENTH  = 32'd429496730;

   // floor((9*old + sample)/10) written as old + floor((sample - old)/10).
   function automatic logic [31:0] smooth(input logic [31:0] old_val,
                                          input logic [31:0] sample);
      logic [33:0] num;
      logic [65:0] prod;
      logic [30:0] quot;
      num  = {2'b00, sample} + DIFF_BIAS - {2'b00, old_val};
      prod = {32'd0, num} * {34'd0, RECIP_TEN};
      quot = prod[RECIP_SHIFT +: 31];
      return old_val + {1'b0, quot} - BIAS_TENTH;
   endfunction

   function automatic logic [31:0] avg2(input logic [31:0] x, input logic [31:0] y);
      logic [32:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      return sum[32:1];
   endfunction

   pps_pkg::word_type prev_a_ff, prev_a_in;
   pps_pkg::word_type prev_b_ff, prev_b_in;
   pps_pkg::word_type prev_gap_ff, prev_gap_in;
   pps_pkg::word_type period_ff, period_in;
   pps_pkg::word_type offset_ff, offset_in;

   pps_pkg::word_type per_a, per_b, gap, new_period, new_offset;
   logic              repeat_hit, commit;

   assign repeat_hit = (slot.item.rise_a == prev_a_ff) || (slot.item.rise_b == prev_b_ff);
   // Drop a repeat at once; a real item waits for room in the output register.
   assign advance    = slot.valid && (repeat_hit || !out_busy);
   assign commit     = advance && !repeat_hit;

   always_comb begin
      per_a      = slot.item.rise_a - prev_a_ff;
      per_b      = slot.item.rise_b - prev_b_ff;
      gap        = slot.item.rise_b - slot.item.rise_a;
      new_period = smooth(period_ff, avg2(per_a, per_b));
      new_offset = smooth(offset_ff, avg2(gap, prev_gap_ff));

      prev_a_in   = commit ? slot.item.rise_a : prev_a_ff;
      prev_b_in   = commit ? slot.item.rise_b : prev_b_ff;
      prev_gap_in = commit ? gap : prev_gap_ff;
      period_in   = commit ? new_period : period_ff;
      offset_in   = commit ? new_offset : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff   <= '0;
         prev_b_ff   <= '0;
         prev_gap_ff <= '0;
         period_ff   <= INIT_PERIOD;
         offset_ff   <= INIT_OFFSET;
      end else begin
         prev_a_ff   <= prev_a_in;
         prev_b_ff   <= prev_b_in;
         prev_gap_ff <= prev_gap_in;
         period_ff   <= period_in;
         offset_ff   <= offset_in;
      end
   end

   assign load.load                    = commit;
   assign load.result.pulse_period_out = new_period;
   assign load.result.sync_offset_out  = new_offset;

endmodule

`default_nettype wire

// ===== src/pps_out_stage.sv =====
// Output register of the pulse period smoother: holds one result until transferred.
// Depends on pps_pkg.
`default_nettype none

module pps_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pps_pkg::load_type   load,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pps_pkg::result_type      rsp_result
);

   logic                valid_ff, valid_in;
   pps_pkg::result_type result_ff, result_in;

   assign busy = valid_ff && !rsp_ready;

   always_comb begin
      valid_in  = load.load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      result_in = load.load ? load.result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== src/pulse_period_smoother.sv =====
// Top level of the pulse period smoother: input register, smoothing core, output register.
// Depends on pps_pkg, pps_if, pps_in_stage, pps_core and pps_out_stage.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+---------------------------------------
//   req_ch  | in        | valid / ready | rise_a, rise_b (32-bit tick stamps)
//   rsp_ch  | out       | valid / ready | pulse_period_out, sync_offset_out
//
// One item per cycle sustained while rsp_ch does not stall; a request is captured in the input
// register, then its result in the output register, from which it is presented on rsp_ch.
// The rate is set by the combinational filter path (one 34x32 reciprocal multiply per value)
// between the input register and the output register.
// An item that repeats either stored stamp is dropped with no result and no state change.
// Reset (synchronous, active high) empties both registers, clears the stamps and the gap,
// and loads INIT_PERIOD and INIT_OFFSET into the smoothed values.
// A stalled response holds its result; a new request is still taken while the input
// register frees up in the same cycle.
`default_nettype none

module pulse_period_smoother #(
   parameter logic [31:0] INIT_PERIOD = 32'd8333,
   parameter logic [31:0] INIT_OFFSET = 32'd400
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pps_req_if.sink     req_ch,
   pps_rsp_if.source   rsp_ch
);

   pps_pkg::item_type   req_item;
   pps_pkg::slot_type   slot;
   pps_pkg::load_type   load;
   pps_pkg::result_type rsp_result;
   logic                advance;
   logic                out_busy;

   assign req_item.rise_a = req_ch.rise_a;
   assign req_item.rise_b = req_ch.rise_b;

   // Capture the request transfer.
   pps_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_item  (req_item),
      .advance   (advance),
      .slot      (slot)
   );

   // Drop repeats, update the tracker and form the reload values.
   pps_core #(
      .INIT_PERIOD (INIT_PERIOD),
      .INIT_OFFSET (INIT_OFFSET)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .slot     (slot),
      .out_busy (out_busy),
      .advance  (advance),
      .load     (load)
   );

   // Hold the result until the response transfer.
   pps_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .busy       (out_busy),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_result (rsp_result)
   );

   assign rsp_ch.pulse_period_out = rsp_result.pulse_period_out;
   assign rsp_ch.sync_offset_out  = rsp_result.sync_offset_out;

endmodule

`default_nettype wire

// ===== src/pps_checker.sv =====
// Port-level checker for the pulse period smoother, bound to the top level.
// Depends on pps_pkg and on the top level's interface ports.
`default_nettype none

module pps_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pps_pkg::word_type pulse_period_out,
   input wire pps_pkg::word_type sync_offset_out
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // A stalled response stays up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pulse_period_out) && $stable(sync_offset_out))
      else $error("response changed while stalled");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

   // A response that was not already up needs an earlier request transfer.
   assert property (@(posedge clock) disable iff (reset)
      !$past(req_xfer, 1) && !$past(req_xfer, 2) && !$past(rsp_valid) |-> !rsp_valid)
      else $error("response without a request");

endmodule

bind pulse_period_smoother pps_port_checker u_pps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .pulse_period_out (rsp_ch.pulse_period_out),
   .sync_offset_out  (rsp_ch.sync_offset_out)
);

`default_nettype wire

// ===== tb/pps_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pulse period smoother: watches both channels, predicts the reload values
// and compares every result transfer. Depends on pps_pkg and pps_if.

module pps_checker #(
   parameter logic [31:0] INIT_PERIOD = 32'd8333,
   parameter logic [31:0] INIT_OFFSET = 32'd400
) (
   input  logic        clock,
   input  logic        reset,
   pps_req_if          req_ch,
   pps_rsp_if          rsp_ch,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int unsigned PRINT_CAP = 40;

   // predictor state
   pps_pkg::word_type   last_a;
   pps_pkg::word_type   last_b;
   pps_pkg::word_type   last_gap;
   pps_pkg::word_type   period_avg;
   pps_pkg::word_type   offset_avg;
   pps_pkg::result_type reload_q[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // new = floor((9*old + sample) / 10); the sum fits in 36 bits
   function automatic pps_pkg::word_type ema_update(input pps_pkg::word_type old,
                                                    input pps_pkg::word_type sample);
      logic [35:0] acc;
      acc = 36'(old) * 36'd9 + 36'(sample);
      return pps_pkg::word_type'(acc / 36'd10);
   endfunction

   // mean of two words taken on the 33-bit sum
   function automatic pps_pkg::word_type mid_point(input pps_pkg::word_type x,
                                                   input pps_pkg::word_type y);
      logic [32:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      return sum[32:1];
   endfunction

   task automatic report_error(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("pps_checker: %0t ns: %s", $time, msg);
   endtask

   task automatic predict_reload(input pps_pkg::word_type a, input pps_pkg::word_type b);
      pps_pkg::word_type gap;
      pps_pkg::word_type per_a;
      pps_pkg::word_type per_b;
      // drop a pair that repeats either stored stamp
      if (a == last_a || b == last_b)
         return;
      per_a      = a - last_a;
      per_b      = b - last_b;
      gap        = b - a;
      period_avg = ema_update(period_avg, mid_point(per_a, per_b));
      offset_avg = ema_update(offset_avg, mid_point(gap, last_gap));
      last_gap   = gap;
      last_a     = a;
      last_b     = b;
      reload_q.push_back('{pulse_period_out: period_avg, sync_offset_out: offset_avg});
   endtask

   always @(posedge clock) begin
      pps_pkg::result_type want;
      if (reset) begin
         last_a     = '0;
         last_b     = '0;
         last_gap   = '0;
         period_avg = INIT_PERIOD;
         offset_avg = INIT_OFFSET;
         reload_q.delete();
      end else begin
         // check the result side first: a request never shows in the same cycle
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reload_q.size() == 0) begin
               report_error($sformatf("result %h/%h with none expected",
                                      rsp_ch.pulse_period_out, rsp_ch.sync_offset_out));
            end else begin
               want = reload_q.pop_front();
               if (rsp_ch.pulse_period_out !== want.pulse_period_out)
                  report_error($sformatf("pulse_period_out %h, expected %h",
                                         rsp_ch.pulse_period_out, want.pulse_period_out));
               if (rsp_ch.sync_offset_out !== want.sync_offset_out)
                  report_error($sformatf("sync_offset_out %h, expected %h",
                                         rsp_ch.sync_offset_out, want.sync_offset_out));
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_reload(req_ch.rise_a, req_ch.rise_b);
      end
      outstanding = reload_q.size();
   end

endmodule

// ===== tb/tb_pulse_period_smoother.sv =====
`timescale 1ns / 1ps
// Testbench top for the pulse period smoother: clock, reset, stamp stimulus and verdict.
// Depends on pps_pkg, pps_if, the block and pps_checker.

module tb_pulse_period_smoother;

   localparam logic [31:0] INIT_PERIOD     = 32'd8333;
   localparam logic [31:0] INIT_OFFSET     = 32'd400;
   localparam int unsigned RANDOM_ITEMS    = 730;   // random pairs, repeats included
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned HOLD_OFF_AT     = 300;
   localparam int unsigned PAUSE_AT        = 600;
   localparam int unsigned NUM_DIRECTED    = 19;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned burst_left;
   bit          hold_off_req;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();

   pulse_period_smoother #(
      .INIT_PERIOD (INIT_PERIOD),
      .INIT_OFFSET (INIT_OFFSET)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pps_checker #(
      .INIT_PERIOD (INIT_PERIOD),
      .INIT_OFFSET (INIT_OFFSET)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Directed pairs. In order: a zero A stamp straight after reset, a zero B stamp,
   // both stamps zero, a first real pair, a repeated A stamp, a steady pair, B ahead
   // of A so the gap wraps, both stamps near the top, a counter wrap to a short period,
   // mixed extremes across the sign bit, then stamps that step back by one tick so
   // every period reads as 2^32-1 and drives the smoothed period toward its ceiling.
   pps_pkg::word_type dir_a [0:NUM_DIRECTED-1] = '{
      32'h0000_0000, 32'h0000_03E8, 32'h0000_0000, 32'h0000_0064, 32'h0000_0064,
      32'h0000_20F1, 32'h0000_417E, 32'hFFFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0040, 32'h0000_003F,
      32'h0000_003E, 32'h0000_003D, 32'h0000_003C, 32'h0000_003B
   };
   pps_pkg::word_type dir_b [0:NUM_DIRECTED-1] = '{
      32'h0000_03E8, 32'h0000_0000, 32'h0000_0000, 32'h0000_0190, 32'h0000_0384,
      32'h0000_2281, 32'h0000_3E80, 32'hFFFF_FFFE, 32'h0000_2000, 32'h0000_0000,
      32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0140, 32'h0000_013F,
      32'h0000_013E, 32'h0000_013D, 32'h0000_013C, 32'h0000_013B
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2ms;
      $display("[pulse_period_smoother] ERROR");
      $finish;
   end

   // Offer one stamp pair and hold it until the transfer. Between bursts, drop valid
   // for a random gap; inside a burst keep valid high so pairs go back to back.
   task automatic send_stamps(input pps_pkg::word_type a, input pps_pkg::word_type b);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat (($urandom_range(7) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1))
            @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 40)
                                                : $urandom_range(12, 1);
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.rise_a <= a;
      req_ch.rise_b <= b;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Stop offering and hold until every predicted reload value has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Result side: ready follows a mode that is re-picked at random (always ready, ready
   // with a chance of three in four, or short random stalls). A hold-off request from the
   // stimulus side forces one long stall so the block backs up into its input.
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned cycle_n;
      int unsigned mode;
      stall_left   = 0;
      cycle_n      = 0;
      mode         = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_n++;
         if (cycle_n % 64 == 0)
            mode = $urandom_range(2);
         if (stall_left == 0 && hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && mode == 2 && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(6, 1);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (mode != 1) || ($urandom_range(3) != 0);
         end
      end
   end

   initial begin : stimulus
      pps_pkg::word_type track_a;
      pps_pkg::word_type track_b;
      pps_pkg::word_type next_a;
      pps_pkg::word_type next_b;
      int unsigned       sent;
      int unsigned       pick;

      hold_off_req   = 1'b0;
      burst_left     = 0;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.rise_a <= '0;
      req_ch.rise_b <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_stamps(dir_a[i], dir_b[i]);
      wait_for_results();

      // Random part: mostly a steady pair of edge trains with jittered periods and
      // offsets, so the filters track something real; the rest is repeats, wild
      // stamps and jumps just below the counter wrap.
      track_a = $urandom;
      track_b = track_a + INIT_OFFSET;
      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if (sent == HOLD_OFF_AT) begin
            // stall the result side and keep offering back to back
            hold_off_req = 1'b1;
            burst_left   = HOLD_OFF_CYCLES + 20;
         end
         if (sent == PAUSE_AT)
            wait_for_results();

         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(4) == 0)
               next_a = track_a + $urandom_range(20000, 1);
            else
               next_a = track_a + INIT_PERIOD - 200 + $urandom_range(400);
            if ($urandom_range(5) == 0)
               next_b = next_a - $urandom_range(3000);     // B ahead of A
            else
               next_b = next_a + $urandom_range(2000);
         end else if (pick < 80) begin
            next_a = track_a;                             // repeat the A stamp
            next_b = track_b + $urandom_range(9000, 1);
         end else if (pick < 88) begin
            next_a = track_a + $urandom_range(9000, 1);
            next_b = track_b;                             // repeat the B stamp
         end else if (pick < 95) begin
            next_a = $urandom;
            next_b = $urandom;
         end else begin
            next_a = 32'hFFFF_FFFF - $urandom_range(30000);
            next_b = next_a + $urandom_range(60000);
         end

         send_stamps(next_a, next_b);
         // advance the tracked trains only when the pair repeats neither tracked stamp
         if (next_a != track_a && next_b != track_b) begin
            track_a = next_a;
            track_b = next_b;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[pulse_period_smoother] OK");
      else
         $display("[pulse_period_smoother] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pps_pkg.sv
src/pps_if.sv
src/pps_in_stage.sv
src/pps_core.sv
src/pps_out_stage.sv
src/pulse_period_smoother.sv
src/pps_checker.sv
tb/pps_checker.sv
tb/tb_pulse_period_smoother.sv
